### sv/lsmf_pkg.sv
// ----------------------------------------------------------------------------
// lsmf_pkg
// Shared types and constants of the line substring match filter.
// ----------------------------------------------------------------------------
package lsmf_pkg;

  // Byte that ends a line
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  // Configuration port
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PAT_LEN_W  = 6;
  localparam int unsigned PAT_WORDS  = 4;
  // Pattern bytes held in the configuration words
  localparam int unsigned PAT_STORED = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD0       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD1       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD2       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD3       = 3'd4;

  // Result counters and their saturation value
  localparam int unsigned          CNT_W   = 10;
  localparam logic [CNT_W-1:0]     CNT_SAT = 10'd1023;

  // Width of an effective pattern length or a cell position
  localparam int unsigned EFF_W = 7;

  typedef logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] pat_words_t;

  // Top level to cell chain
  typedef struct packed {
    logic step;        // searchable byte enters the chain
    logic line_clear;  // line ends, drop all partial matches
  } search_ctrl_t;

  // Chain to each cell
  typedef struct packed {
    logic step;
    logic flush;       // line end or a full match this cycle
  } cell_ctrl_t;

endpackage

### sv/lsmf_cell.sv
// ----------------------------------------------------------------------------
// lsmf_cell
// One cell of the match chain: holds whether pattern bytes 0..CellIdx match
// the bytes that ended at the previous searchable byte.
// ----------------------------------------------------------------------------
module lsmf_cell
  import lsmf_pkg::*;
#(
  parameter int unsigned CellIdx = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic [7:0]           byte_i,
  input  logic [7:0]           pat_byte_i,
  input  logic                 prev_match_i,
  input  logic [EFF_W-1:0]     eff_last_i,
  output logic                 match_o,
  output logic                 tap_o
);

  logic match_q, match_d;
  logic match_new;

  // Extend the neighbour's partial match by the incoming byte
  assign match_new = prev_match_i && (byte_i == pat_byte_i);

  // Report a full match when this cell carries the last pattern byte
  assign tap_o = match_new && (EFF_W'(CellIdx) == eff_last_i);

  // Drop on flush, advance on a searchable byte, else hold
  always_comb begin
    match_d = match_q;
    if (ctrl_i.flush) begin
      match_d = 1'b0;
    end else if (ctrl_i.step) begin
      match_d = match_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign match_o = match_q;

endmodule

### sv/lsmf_chain.sv
// ----------------------------------------------------------------------------
// lsmf_chain
// Row of match cells, one per pattern position; each cell hands its partial
// match to the next cell on every searchable byte.
// ----------------------------------------------------------------------------
module lsmf_chain
  import lsmf_pkg::*;
#(
  parameter int unsigned NumCells = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  search_ctrl_t     ctrl_i,
  input  logic [7:0]       byte_i,
  input  pat_words_t       pat_words_i,
  input  logic [EFF_W-1:0] eff_last_i,
  output logic             hit_o
);

  logic [NumCells-1:0] match;
  logic [NumCells-1:0] tap;
  logic                hit;
  cell_ctrl_t          cell_ctrl;

  // A full match ends the current attempt, as does the end of a line
  assign hit             = ctrl_i.step && (|tap);
  assign cell_ctrl.step  = ctrl_i.step;
  assign cell_ctrl.flush = ctrl_i.line_clear || hit;

  for (genvar j = 0; j < NumCells; j++) begin : g_cell
    logic [7:0] pat_byte;
    logic       prev_match;

    // Pattern bytes beyond the configuration words read as zero
    if (j < PAT_STORED) begin : g_pat
      assign pat_byte = pat_words_i[j / 8][8 * (j % 8) +: 8];
    end else begin : g_zero
      assign pat_byte = 8'd0;
    end

    if (j == 0) begin : g_first
      assign prev_match = 1'b1;
    end else begin : g_next
      assign prev_match = match[j-1];
    end

    lsmf_cell #(
      .CellIdx (j)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .byte_i       (byte_i),
      .pat_byte_i   (pat_byte),
      .prev_match_i (prev_match),
      .eff_last_i   (eff_last_i),
      .match_o      (match[j]),
      .tap_o        (tap[j])
    );
  end

  assign hit_o = hit;

endmodule

### sv/line_substring_match_filter.sv
// ----------------------------------------------------------------------------
// line_substring_match_filter
// Splits a byte stream into lines and counts pattern occurrences per line.
// ----------------------------------------------------------------------------
// The block takes one byte request per cycle. Ordinary bytes give no result;
// a newline or an end request gives one result, presented from the output
// register in the cycle after the request is taken. Input ready follows the
// output register: a request is taken in every cycle while that register is
// empty or being drained, so with a ready consumer the block sustains one
// byte per clock. The search is a row of PATTERN_MAX cells, each holding one
// partial match bit that moves one cell along per searchable byte, so a
// match is known in the cycle its last byte arrives. Write pattern registers
// through the plain write port while no request is in flight (not enforced).
// ----------------------------------------------------------------------------
module line_substring_match_filter
  import lsmf_pkg::*;
#(
  parameter int unsigned LINE_MAX    = 1024,
  parameter int unsigned PATTERN_MAX = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // byte requests
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  is_end_i,
  // line results
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  line_valid_o,
  output logic                  line_matched_o,
  output logic [CNT_W-1:0]      match_count_o,
  output logic [CNT_W-1:0]      first_match_start_o,
  output logic [CNT_W-1:0]      stored_length_o,
  output logic                  truncated_o,
  output logic                  found_any_o,
  output logic                  stream_end_o,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned LW = (LINE_MAX > 2) ? $clog2(LINE_MAX) : 1;
  localparam logic [LW-1:0] LEN_LIMIT = LW'(LINE_MAX - 1);

  // Configuration registers
  logic [PAT_LEN_W-1:0] pat_len_q, pat_len_d;
  pat_words_t           pat_words_q, pat_words_d;

  // Line state
  logic [LW-1:0]    line_len_q, line_len_d;
  logic [LW-1:0]    first_q, first_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             zero_seen_q, zero_seen_d;
  logic             ovf_q, ovf_d;
  logic             found_q, found_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic             res_line_valid_q, res_matched_q, res_trunc_q, res_found_q, res_end_q;
  logic [CNT_W-1:0] res_count_q, res_first_q, res_len_q;
  logic             res_line_valid_d, res_matched_d, res_trunc_d, res_found_d, res_end_d;
  logic [CNT_W-1:0] res_count_d, res_first_d, res_len_d;

  logic             accept, is_nl, is_data, room, keep, hit;
  logic [EFF_W-1:0] eff, eff_last;
  search_ctrl_t     sctrl;

  // Write configuration registers
  always_comb begin
    pat_len_d   = pat_len_q;
    pat_words_d = pat_words_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PATTERN_LEN: pat_len_d      = cfg_data_i[PAT_LEN_W-1:0];
        CFG_WORD0:       pat_words_d[0] = cfg_data_i;
        CFG_WORD1:       pat_words_d[1] = cfg_data_i;
        CFG_WORD2:       pat_words_d[2] = cfg_data_i;
        CFG_WORD3:       pat_words_d[3] = cfg_data_i;
        default:         pat_len_d      = pat_len_q;
      endcase
    end
  end

  // Effective pattern length: zero reads as one, clamp at the cell count
  always_comb begin
    eff = EFF_W'(pat_len_q);
    if (pat_len_q == '0) begin
      eff = EFF_W'(1);
    end
    if (eff > EFF_W'(PATTERN_MAX)) begin
      eff = EFF_W'(PATTERN_MAX);
    end
  end
  assign eff_last = eff - EFF_W'(1);

  // Classify the request
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_nl      = !is_end_i && (data_byte_i == NEWLINE_BYTE);
  assign is_data    = !is_end_i && !is_nl;
  assign room       = line_len_q < LEN_LIMIT;
  assign keep       = accept && is_data && room;

  assign sctrl.step       = keep && (data_byte_i != 8'd0) && !zero_seen_q;
  assign sctrl.line_clear = accept && !is_data;

  lsmf_chain #(
    .NumCells (PATTERN_MAX)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (sctrl),
    .byte_i      (data_byte_i),
    .pat_words_i (pat_words_q),
    .eff_last_i  (eff_last),
    .hit_o       (hit)
  );

  // Advance line state
  always_comb begin
    line_len_d  = line_len_q;
    first_d     = first_q;
    count_d     = count_q;
    zero_seen_d = zero_seen_q;
    ovf_d       = ovf_q;
    found_d     = found_q;
    if (sctrl.line_clear) begin
      line_len_d  = '0;
      first_d     = '0;
      count_d     = '0;
      zero_seen_d = 1'b0;
      ovf_d       = 1'b0;
      if (is_end_i) begin
        found_d = 1'b0;
      end else if (count_q != '0) begin
        found_d = 1'b1;
      end
    end else begin
      if (keep) begin
        line_len_d = line_len_q + LW'(1);
        if (data_byte_i == 8'd0) begin
          zero_seen_d = 1'b1;
        end
      end
      if (accept && is_data && !room) begin
        ovf_d = 1'b1;
      end
      if (hit) begin
        if (count_q == '0) begin
          first_d = LW'(32'(line_len_q) + 32'd1 - 32'(eff));
        end
        if (count_q != CNT_SAT) begin
          count_d = count_q + CNT_W'(1);
        end
      end
    end
  end

  // Build the result of a line end and hold it until taken
  always_comb begin
    out_valid_d      = out_valid_q;
    res_line_valid_d = res_line_valid_q;
    res_matched_d    = res_matched_q;
    res_count_d      = res_count_q;
    res_first_d      = res_first_q;
    res_len_d        = res_len_q;
    res_trunc_d      = res_trunc_q;
    res_found_d      = res_found_q;
    res_end_d        = res_end_q;
    if (sctrl.line_clear) begin
      out_valid_d      = 1'b1;
      res_line_valid_d = is_nl || (line_len_q != '0);
      res_matched_d    = res_line_valid_d && (count_q != '0);
      res_count_d      = res_line_valid_d ? count_q : '0;
      res_first_d      = '0;
      if (res_matched_d) begin
        res_first_d = (32'(first_q) > 32'(CNT_SAT)) ? CNT_SAT : CNT_W'(first_q);
      end
      res_len_d = '0;
      if (res_line_valid_d) begin
        res_len_d = (32'(line_len_q) > 32'(CNT_SAT)) ? CNT_SAT : CNT_W'(line_len_q);
      end
      res_trunc_d = res_line_valid_d && ovf_q;
      res_found_d = found_q || res_matched_d;
      res_end_d   = is_end_i;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q   <= PAT_LEN_W'(1);
      pat_words_q <= '0;
      line_len_q  <= '0;
      first_q     <= '0;
      count_q     <= '0;
      zero_seen_q <= 1'b0;
      ovf_q       <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pat_len_q   <= pat_len_d;
      pat_words_q <= pat_words_d;
      line_len_q  <= line_len_d;
      first_q     <= first_d;
      count_q     <= count_d;
      zero_seen_q <= zero_seen_d;
      ovf_q       <= ovf_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    res_line_valid_q <= res_line_valid_d;
    res_matched_q    <= res_matched_d;
    res_count_q      <= res_count_d;
    res_first_q      <= res_first_d;
    res_len_q        <= res_len_d;
    res_trunc_q      <= res_trunc_d;
    res_found_q      <= res_found_d;
    res_end_q        <= res_end_d;
  end

  assign out_valid_o         = out_valid_q;
  assign line_valid_o        = res_line_valid_q;
  assign line_matched_o      = res_matched_q;
  assign match_count_o       = res_count_q;
  assign first_match_start_o = res_first_q;
  assign stored_length_o     = res_len_q;
  assign truncated_o         = res_trunc_q;
  assign found_any_o         = res_found_q;
  assign stream_end_o        = res_end_q;

endmodule
